>>> design/lav_pkg.sv
package lav_pkg;

  localparam int FracBits  = 16;
  localparam int UnitBits  = 30;
  localparam int ProdFrac  = UnitBits + FracBits;
  // Q1.30 x Q16.16 products drop back to Q16.16
  localparam int ShiftBits = ProdFrac - FracBits;

  localparam int InW  = 288;
  localparam int OutW = 128;

  localparam logic [1:0] RowSide = 2'd0;
  localparam logic [1:0] RowUp   = 2'd1;
  localparam logic [1:0] RowFwd  = 2'd2;

  typedef logic signed [31:0] w32_t;
  typedef logic signed [32:0] w33_t;
  typedef logic signed [63:0] w64_t;
  typedef logic signed [65:0] w66_t;

  localparam w66_t SatHi = 66'sd2147483647;
  localparam w66_t SatLo = -66'sd2147483648;

  typedef struct packed {
    logic [2:0][31:0] eye;
    logic [2:0][32:0] fwd;
    logic [2:0][31:0] up;
  } item_t;

  typedef struct packed {
    logic [31:0]      shift;
    logic [2:0][31:0] elem;
  } row_t;

  // right shift by ShiftBits, round to nearest, ties away from zero
  function automatic w66_t rnd_shr(input w66_t v);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r   = (mag + (66'd1 << (ShiftBits - 1))) >> ShiftBits;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

  function automatic w32_t sat32(input w66_t v);
    w32_t r;
    if (v > SatHi) r = 32'sh7fffffff;
    else if (v < SatLo) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

>>> design/look_at_view_matrix.sv
// Each item passes the bit-serial square root (32 steps) and divide lanes (31 steps) twice,
// each square root preceded by range-scaling steps; a zero vector (target equals eye) skips
// them. The engine takes a new item only after handing the last one's rows to the output
// bank; the three rows then leave one per cycle while m_axis_tready_i is high.
// An input queue of two items and a three-row output bank overlap adjacent items.
// Reset (rst_ni low, asynchronous) empties the queue, the engine and the output bank.
module look_at_view_matrix import lav_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // elem_x, elem_y, elem_z, shift
  output logic [OutW-1:0] m_axis_tdata_o,
  // row_index
  output logic [1:0]      m_axis_tuser_o,
  output logic            m_axis_tlast_o
);

  logic       item_valid, item_ready;
  item_t      item;
  logic       load_valid, load_ready;
  row_t [2:0] rows;

  lav_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_o         (item)
  );

  lav_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .load_valid_o(load_valid),
    .load_ready_i(load_ready),
    .rows_o      (rows)
  );

  lav_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_valid_i   (load_valid),
    .load_ready_o   (load_ready),
    .rows_i         (rows),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

`ifndef NO_ASSERTIONS
  a_last_is_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tuser_o == RowFwd)))
    else $error("tlast not aligned with final row");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o)
      |=> (m_axis_tvalid_o && m_axis_tuser_o == $past(m_axis_tuser_o) + 2'd1))
    else $error("rows of a run not contiguous");

  a_no_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o != 2'd3))
    else $error("invalid row index");
`endif

endmodule

>>> design/lav_front.sv
module lav_front import lav_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upward_x, upward_y, upward_z
  input  logic [InW-1:0]  s_axis_tdata_i,
  output logic            item_valid_o,
  input  logic            item_ready_i,
  output item_t           item_o
);

  item_t      q_mem [2];
  item_t      entry;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      entry.eye[i] = s_axis_tdata_i[32*i +: 32];
      entry.up[i]  = s_axis_tdata_i[192 + 32*i +: 32];
      entry.fwd[i] = 33'($signed({s_axis_tdata_i[96 + 32*i + 31], s_axis_tdata_i[96 + 32*i +: 32]})
                   - $signed({s_axis_tdata_i[32*i + 31], s_axis_tdata_i[32*i +: 32]}));
    end
  end

  assign s_axis_tready_o = (cnt_q != 2'd2);
  assign item_valid_o    = (cnt_q != 2'd0);
  assign item_o          = q_mem[rd_ptr_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= entry;
  end

endmodule

>>> design/lav_norm.sv
module lav_norm import lav_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [2:0][63:0] vec_i,
  output logic             done_o,
  output logic [2:0][31:0] unit_o
);

  typedef enum logic [2:0] {N_IDLE, N_SCALE, N_SQ, N_SQRT, N_DIV, N_DONE} state_e;

  state_e           state_q;
  logic             done_q;
  logic [4:0]       cnt_q;
  logic [1:0]       sel_q;
  logic [63:0]      mag_q [3];
  logic             neg_q [3];
  logic [63:0]      sum_q;
  logic [34:0]      rem_q;
  logic [31:0]      root_q;
  logic [31:0]      drem_q [3];
  logic [30:0]      quo_q [3];
  logic [2:0][31:0] unit_q;

  logic        any34, any30, lo25, lo29, in_zero;
  logic [34:0] rem_sh, trial;
  logic [32:0] dsh [3];
  logic [59:0] sq;
  logic [31:0] q32 [3];

  always_comb begin
    any34   = 1'b0;
    any30   = 1'b0;
    lo25    = 1'b1;
    lo29    = 1'b1;
    in_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      any34   = any34 | (|mag_q[i][63:34]);
      any30   = any30 | (|mag_q[i][63:30]);
      lo25    = lo25 & ~(|mag_q[i][63:25]);
      lo29    = lo29 & ~(|mag_q[i][63:29]);
      in_zero = in_zero & ~(|vec_i[i]);
    end
    sq     = mag_q[sel_q][29:0] * mag_q[sel_q][29:0];
    rem_sh = {rem_q[32:0], sum_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    for (int i = 0; i < 3; i++) begin
      dsh[i] = {drem_q[i], (cnt_q == 5'd0) ? mag_q[i][0] : 1'b0};
      q32[i] = {1'b0, quo_q[i]};
    end
  end

  assign done_o = done_q;
  assign unit_o = unit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= 5'd0;
      sel_q   <= 2'd0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        N_IDLE: begin
          if (start_i) begin
            if (in_zero) done_q <= 1'b1;
            else state_q <= N_SCALE;
          end
        end
        N_SCALE: begin
          if (!any30 && !lo29) begin
            state_q <= N_SQ;
            sel_q   <= 2'd0;
          end
        end
        N_SQ: begin
          sel_q <= sel_q + 2'd1;
          if (sel_q == 2'd2) begin
            state_q <= N_SQRT;
            cnt_q   <= 5'd0;
          end
        end
        N_SQRT: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= N_DIV;
            cnt_q   <= 5'd0;
          end
        end
        N_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd30) state_q <= N_DONE;
        end
        N_DONE: begin
          done_q  <= 1'b1;
          state_q <= N_IDLE;
        end
        default: state_q <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][63];
            mag_q[i] <= vec_i[i][63] ? 64'(-$signed(vec_i[i])) : vec_i[i];
          end
          if (in_zero) unit_q <= '0;
        end
      end
      N_SCALE: begin
        // truncating shifts compose, so stepping by four is exact
        for (int i = 0; i < 3; i++) begin
          if (any34) mag_q[i] <= mag_q[i] >> 4;
          else if (any30) mag_q[i] <= mag_q[i] >> 1;
          else if (lo25) mag_q[i] <= mag_q[i] << 4;
          else if (lo29) mag_q[i] <= mag_q[i] << 1;
        end
        sum_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
      end
      N_SQ: sum_q <= sum_q + 64'(sq);
      N_SQRT: begin
        sum_q <= sum_q << 2;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[30:0], 1'b0};
        end
        for (int i = 0; i < 3; i++) begin
          drem_q[i] <= {3'd0, mag_q[i][29:1]};
          quo_q[i]  <= '0;
        end
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (dsh[i] >= {1'b0, root_q}) begin
            drem_q[i] <= 32'(dsh[i] - {1'b0, root_q});
            quo_q[i]  <= {quo_q[i][29:0], 1'b1};
          end else begin
            drem_q[i] <= dsh[i][31:0];
            quo_q[i]  <= {quo_q[i][29:0], 1'b0};
          end
        end
      end
      N_DONE: begin
        for (int i = 0; i < 3; i++) unit_q[i] <= neg_q[i] ? 32'(-q32[i]) : q32[i];
      end
      default: ;
    endcase
  end

endmodule

>>> design/lav_back.sv
module lav_back import lav_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  output logic            item_ready_o,
  input  item_t           item_i,
  output logic            load_valid_o,
  input  logic            load_ready_i,
  output row_t [2:0]      rows_o
);

  typedef enum logic [2:0] {B_IDLE, B_NF, B_X1, B_NS, B_X2, B_DOT, B_HAND} state_e;

  localparam logic [3:0] XSteps = 4'd6;
  localparam logic [3:0] DSteps = 4'd9;

  state_e     state_q;
  logic       nstart_q;
  logic [3:0] cnt_q, ps_q;
  logic       pv_q;

  w32_t eye_q [3], up_q [3], fu_q [3], su_q [3], nup_q [3], sh_q [3];
  w33_t fwd_q [3];
  w64_t side_q [3];
  w64_t prod_q;
  w66_t acc_q;

  logic [2:0][63:0] nvec;
  logic [2:0][31:0] nout;
  logic             ndone;

  logic [3:0] xs, ds, pds, nsteps;
  w32_t       mul_a, mul_b;
  logic       issue, op_state, op_done;
  w66_t       prod_ext, cross_sum, dot_sum;

  // cross-product term: {a index, b index}; odd steps are subtracted
  function automatic logic [3:0] xsel(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      4'd0:    r = {2'd1, 2'd2};
      4'd1:    r = {2'd2, 2'd1};
      4'd2:    r = {2'd2, 2'd0};
      4'd3:    r = {2'd0, 2'd2};
      4'd4:    r = {2'd0, 2'd1};
      4'd5:    r = {2'd1, 2'd0};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  // dot-product term: {row, column}
  function automatic logic [3:0] dsel(input logic [3:0] s);
    logic [3:0] r;
    case (s)
      4'd0:    r = {RowSide, 2'd0};
      4'd1:    r = {RowSide, 2'd1};
      4'd2:    r = {RowSide, 2'd2};
      4'd3:    r = {RowUp, 2'd0};
      4'd4:    r = {RowUp, 2'd1};
      4'd5:    r = {RowUp, 2'd2};
      4'd6:    r = {RowFwd, 2'd0};
      4'd7:    r = {RowFwd, 2'd1};
      4'd8:    r = {RowFwd, 2'd2};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  lav_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(nstart_q),
    .vec_i  (nvec),
    .done_o (ndone),
    .unit_o (nout)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nvec[i] = (state_q == B_NS) ? side_q[i] : 64'(fwd_q[i]);
    end
    xs     = xsel(cnt_q);
    ds     = dsel(cnt_q);
    pds    = dsel(ps_q);
    nsteps = (state_q == B_DOT) ? DSteps : XSteps;
    mul_a  = '0;
    mul_b  = '0;
    case (state_q)
      B_X1: begin
        mul_a = fu_q[xs[3:2]];
        mul_b = up_q[xs[1:0]];
      end
      B_X2: begin
        mul_a = su_q[xs[3:2]];
        mul_b = fu_q[xs[1:0]];
      end
      B_DOT: begin
        case (ds[3:2])
          RowSide: mul_a = su_q[ds[1:0]];
          RowUp:   mul_a = nup_q[ds[1:0]];
          default: mul_a = -fu_q[ds[1:0]];
        endcase
        mul_b = eye_q[ds[1:0]];
      end
      default: ;
    endcase
    op_state  = (state_q == B_X1) || (state_q == B_X2) || (state_q == B_DOT);
    issue     = op_state && (cnt_q < nsteps);
    op_done   = pv_q && (ps_q == nsteps - 4'd1);
    prod_ext  = 66'(prod_q);
    cross_sum = acc_q - prod_ext;
    dot_sum   = acc_q + prod_ext;
  end

  assign item_ready_o = (state_q == B_IDLE);
  assign load_valid_o = (state_q == B_HAND);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rows_o[0].elem[i] = su_q[i];
      rows_o[1].elem[i] = nup_q[i];
      rows_o[2].elem[i] = -fu_q[i];
      rows_o[i].shift   = sh_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      nstart_q <= 1'b0;
      cnt_q    <= 4'd0;
      ps_q     <= 4'd0;
      pv_q     <= 1'b0;
    end else begin
      nstart_q <= 1'b0;
      pv_q     <= issue;
      ps_q     <= cnt_q;
      if (issue) cnt_q <= cnt_q + 4'd1;
      case (state_q)
        B_IDLE: begin
          if (item_valid_i) begin
            state_q  <= B_NF;
            nstart_q <= 1'b1;
          end
        end
        B_NF: begin
          if (ndone) begin
            state_q <= B_X1;
            cnt_q   <= 4'd0;
          end
        end
        B_X1: begin
          if (op_done) begin
            state_q  <= B_NS;
            nstart_q <= 1'b1;
          end
        end
        B_NS: begin
          if (ndone) begin
            state_q <= B_X2;
            cnt_q   <= 4'd0;
          end
        end
        B_X2: begin
          if (op_done) begin
            state_q <= B_DOT;
            cnt_q   <= 4'd0;
          end
        end
        B_DOT: begin
          if (op_done) state_q <= B_HAND;
        end
        B_HAND: begin
          if (load_ready_i) state_q <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == B_IDLE && item_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        eye_q[i] <= item_i.eye[i];
        fwd_q[i] <= item_i.fwd[i];
        up_q[i]  <= item_i.up[i];
      end
    end
    if (state_q == B_NF && ndone) begin
      for (int i = 0; i < 3; i++) fu_q[i] <= nout[i];
    end
    if (state_q == B_NS && ndone) begin
      for (int i = 0; i < 3; i++) su_q[i] <= nout[i];
    end
    if (pv_q) begin
      case (state_q)
        B_X1, B_X2: begin
          if (!ps_q[0]) acc_q <= prod_ext;
          else if (state_q == B_X1) side_q[ps_q[2:1]] <= 64'(cross_sum);
          else nup_q[ps_q[2:1]] <= sat32(rnd_shr(cross_sum));
        end
        B_DOT: begin
          if (pds[1:0] == 2'd0) acc_q <= prod_ext;
          else acc_q <= dot_sum;
          if (pds[1:0] == 2'd2) sh_q[pds[3:2]] <= sat32(-rnd_shr(dot_sum));
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/lav_out.sv
module lav_out import lav_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_valid_i,
  output logic            load_ready_o,
  input  row_t [2:0]      rows_i,
  output logic            m_axis_tvalid_o,
  input  logic            m_axis_tready_i,
  // elem_x, elem_y, elem_z, shift
  output logic [OutW-1:0] m_axis_tdata_o,
  // row_index
  output logic [1:0]      m_axis_tuser_o,
  output logic            m_axis_tlast_o
);

  row_t [2:0] bank_q;
  logic       busy_q;
  logic [1:0] idx_q;

  assign load_ready_o    = !busy_q;
  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = bank_q[idx_q];
  assign m_axis_tuser_o  = idx_q;
  assign m_axis_tlast_o  = (idx_q == RowFwd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= RowSide;
    end else if (!busy_q) begin
      if (load_valid_i) begin
        busy_q <= 1'b1;
        idx_q  <= RowSide;
      end
    end else if (m_axis_tready_i) begin
      if (idx_q == RowFwd) busy_q <= 1'b0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_valid_i && !busy_q) bank_q <= rows_i;
  end

endmodule
